### design/bdq_pkg.sv
package bdq_pkg;

  localparam int DEPTH      = 8;
  localparam int DATA_WIDTH = 32;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FIELD_W = 32;
  localparam int COUNT_FIELD_W = 4;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // ring index arithmetic, both operands below DEPTH
  function automatic ptr_t ring_add(ptr_t a, ptr_t b);
    logic [PTR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (PTR_W + 1)'(DEPTH)) begin
      sum = sum - (PTR_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic ptr_t ring_inc(ptr_t a);
    return (a == PTR_W'(DEPTH - 1)) ? '0 : a + PTR_W'(1);
  endfunction

  function automatic ptr_t ring_dec(ptr_t a);
    return (a == '0) ? PTR_W'(DEPTH - 1) : a - PTR_W'(1);
  endfunction

  // sign-extend or truncate a stored entry to the result field
  function automatic logic signed [FIELD_W-1:0] to_field(data_t v);
    return FIELD_W'(signed'(v));
  endfunction

endpackage

### design/bdq_req_if.sv
interface bdq_req_if;
  import bdq_pkg::*;

  logic               valid;
  logic               ready;
  mode_t              mode;
  logic signed [31:0] push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

### design/bdq_rsp_if.sv
interface bdq_rsp_if;
  import bdq_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic signed [31:0] popped_value;
  logic [3:0]         entry_count;

  modport source (output valid, output status, output popped_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input popped_value, input entry_count,
                  output ready);
endinterface

### design/bdq_ram.sv
module bdq_ram #(
  parameter int DATA_W = 32,
  parameter int WORDS  = 8
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(WORDS)-1:0]  waddr,
  input  logic [DATA_W-1:0]         wdata,
  input  logic                      re,
  input  logic [$clog2(WORDS)-1:0]  raddr,
  output logic [DATA_W-1:0]         rdata
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/bounded_deque.sv
// Fixed-capacity double-ended queue of DEPTH entries held as a ring buffer in a
// single RAM with one write and one registered read port. Each request (push front,
// push back, pop front, pop back) gives exactly one response with a status, the
// popped value (zero unless a pop succeeds) and the entry count afterwards. Pointer
// and count update in the cycle a request is taken, so one request per cycle is
// sustained while responses are taken; a response passes the middle stage, alongside
// the RAM read, and then the output register. A stalled response holds the
// pipeline, and the block takes no request while its middle stage cannot drain.
// No clearing pass is needed after reset: only pushed entries are ever read.
module bounded_deque
  import bdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bdq_req_if.sink   req,
  bdq_rsp_if.source rsp
);

  ptr_t front;
  ptr_t front_next;
  cnt_t count;
  cnt_t count_next;

  logic    s1_valid;
  status_t s1_status;
  cnt_t    s1_count;
  logic    s1_pop;

  logic    accept;
  logic    s1_move;
  logic    full;
  logic    empty;
  status_t status_next;
  logic    pop_ok;
  logic    ram_we;
  ptr_t    ram_waddr;
  logic    ram_re;
  ptr_t    ram_raddr;
  data_t   ram_rdata;
  ptr_t    back_slot;
  ptr_t    last_slot;

  assign s1_move   = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !rst && (!s1_valid || s1_move);
  assign accept    = req.valid && req.ready;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  // count is below DEPTH on a push and above zero on a pop
  assign back_slot = ring_add(front, count[PTR_W-1:0]);
  assign last_slot = ring_add(front, PTR_W'(count - CNT_W'(1)));

  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = STATUS_DONE;
    pop_ok      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = back_slot;
    ram_re      = 1'b0;
    ram_raddr   = front;
    unique case (req.mode)
      MODE_PUSH_FRONT: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          front_next = ring_dec(front);
          count_next = count + CNT_W'(1);
          ram_we     = accept;
          ram_waddr  = ring_dec(front);
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          count_next = count + CNT_W'(1);
          ram_we     = accept;
          ram_waddr  = back_slot;
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          front_next = ring_inc(front);
          count_next = count - CNT_W'(1);
          pop_ok     = 1'b1;
          ram_re     = accept;
          ram_raddr  = front;
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          count_next = count - CNT_W'(1);
          pop_ok     = 1'b1;
          ram_re     = accept;
          ram_raddr  = last_slot;
        end
      end
      default: begin
        status_next = STATUS_DONE;
      end
    endcase
  end

  bdq_ram #(
    .DATA_W (DATA_WIDTH),
    .WORDS  (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (DATA_WIDTH'(req.push_value)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

  // middle stage waits for the ram read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status_next;
      s1_count  <= count_next;
      s1_pop    <= pop_ok;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_move) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp.status       <= s1_status;
      rsp.entry_count  <= COUNT_FIELD_W'(s1_count);
      rsp.popped_value <= s1_pop ? to_field(ram_rdata) : '0;
    end
  end

endmodule

### sim/testbench.sv
module testbench;
  import bdq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int DRAIN_CYCLES = 10;
  localparam int CHUNK_COUNT = 20;
  localparam int CHUNK_LEN = 40;

  typedef struct {
    status_t            status;
    logic signed [31:0] value;
    logic [3:0]         count;
  } outcome_t;

  // ring-buffer mirror of the deque plus the responses still owed
  class deque_tracker;
    data_t    store[DEPTH];
    int       head;
    int       fill;
    outcome_t awaited[$];
    int       errors;

    function new();
      head = 0;
      fill = 0;
      errors = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_request(mode_t m, logic signed [31:0] v);
      outcome_t want;
      data_t    d;
      d = v[DATA_WIDTH-1:0];
      want.status = STATUS_DONE;
      want.value = '0;
      case (m)
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (fill == DEPTH) begin
            want.status = STATUS_FULL;
          end else if (m == MODE_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            store[head] = d;
            fill++;
          end else begin
            store[(head + fill) % DEPTH] = d;
            fill++;
          end
        end
        default: begin
          if (fill == 0) begin
            want.status = STATUS_EMPTY;
          end else if (m == MODE_POP_FRONT) begin
            d = store[head];
            head = (head + 1) % DEPTH;
            fill--;
            want.value = 32'(signed'(d));
          end else begin
            d = store[(head + fill - 1) % DEPTH];
            fill--;
            want.value = 32'(signed'(d));
          end
        end
      endcase
      want.count = 4'(fill);
      awaited.push_back(want);
    endfunction

    function void check_response(status_t s, logic signed [31:0] v, logic [3:0] c);
      outcome_t want;
      if (awaited.size() == 0) begin
        $error("response with nothing outstanding: status %0d value %0d count %0d",
               s, v, c);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (s !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, s);
        errors++;
      end
      if (v !== want.value) begin
        $error("popped_value: expected %0d, got %0d", want.value, v);
        errors++;
      end
      if (c !== want.count) begin
        $error("entry_count: expected %0d, got %0d", want.count, c);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   hold_off_now;
  int   quiet_cycles;

  deque_tracker book = new();

  bdq_req_if req_ch();
  bdq_rsp_if rsp_ch();

  bounded_deque dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(mode_t m, logic signed [31:0] v);
    req_ch.valid <= 1'b1;
    req_ch.mode <= m;
    req_ch.push_value <= v;
    do @(posedge clk); while (!req_ch.ready);
    book.note_request(m, v);
    @(negedge clk);
  endtask

  task automatic sender_gap(int n);
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_gapped(mode_t m, logic signed [31:0] v);
    send_request(m, v);
    sender_gap(gap_len());
  endtask

  task automatic wait_all_answered();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (book.pending() != 0);
  endtask

  task automatic run_directed();
    send_gapped(MODE_POP_FRONT, 32'sd5);
    send_gapped(MODE_POP_BACK, -32'sd5);
    send_gapped(MODE_PUSH_FRONT, 32'sh7fff_ffff);
    send_gapped(MODE_PUSH_BACK, 32'sh8000_0000);
    send_gapped(MODE_PUSH_FRONT, -32'sd1);
    send_gapped(MODE_PUSH_BACK, '0);
    for (int i = 1; i <= 4; i++) begin
      send_gapped(MODE_PUSH_FRONT, 32'(i * 32'h1111_1111));
    end
    // queue full now, both pushes must bounce
    send_gapped(MODE_PUSH_BACK, 32'sh5a5a_5a5a);
    send_gapped(MODE_PUSH_FRONT, 32'sha5a5_a5a5);
    send_gapped(MODE_POP_BACK, '0);
    send_gapped(MODE_POP_FRONT, '0);
    send_gapped(MODE_POP_BACK, '0);
    for (int i = 0; i < 5; i++) begin
      send_gapped((i % 2) ? MODE_POP_BACK : MODE_POP_FRONT, '0);
    end
    send_gapped(MODE_POP_FRONT, 32'sh7fff_ffff);
  endtask

  task automatic run_random();
    int    push_bias;
    bit    burst;
    mode_t m;
    for (int k = 0; k < CHUNK_COUNT; k++) begin
      case ($urandom_range(0, 2))
        0: push_bias = 25;
        1: push_bias = 50;
        default: push_bias = 75;
      endcase
      burst = ($urandom_range(0, 3) == 0);
      if (k == 3) begin
        // receiver goes quiet while requests keep coming
        hold_off_now = 1'b1;
        push_bias = 90;
        burst = 1'b1;
      end
      if (k == 10) begin
        wait_all_answered();
      end
      for (int i = 0; i < CHUNK_LEN; i++) begin
        if ($urandom_range(0, 99) < push_bias) begin
          m = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        end else begin
          m = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
        end
        send_request(m, pick_value());
        if (!burst) begin
          sender_gap(gap_len());
        end
      end
    end
  endtask

  // response side: random back-pressure, occasional long hold-off
  initial begin
    int  hold;
    int  cyc;
    bit  free_run;
    hold = 0;
    cyc = 0;
    free_run = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 100 == 0) begin
        free_run = ($urandom_range(0, 3) == 0);
      end
      if (hold_off_now) begin
        hold_off_now = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        hold--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!free_run) begin
          hold = gap_len();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      book.check_response(rsp_ch.status, rsp_ch.popped_value, rsp_ch.entry_count);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    hold_off_now = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_PUSH_FRONT;
    req_ch.push_value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_directed();
    run_random();
    wait_all_answered();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
design/bdq_pkg.sv
design/bdq_req_if.sv
design/bdq_rsp_if.sv
design/bdq_ram.sv
design/bounded_deque.sv
sim/testbench.sv
